// ===== design/acfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp_pkg: shared types and constants of the ASCII command frame parser
// Byte codes, register indexes, status codes and the classified-byte record
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package acfp_pkg;

	// Parameter text limit and derived widths.
	localparam int PARAM_TEXT_SIZE = 16;
	localparam int TEXT_CNT_W      = $clog2(PARAM_TEXT_SIZE + 1);
	localparam int MANT_W          = 50;
	localparam int FRAC_W          = 4;
	localparam int CFG_IDX_W       = 3;

	localparam logic [TEXT_CNT_W-1:0] TEXT_LIMIT = TEXT_CNT_W'(PARAM_TEXT_SIZE);
	localparam logic [MANT_W-1:0]     MANT_MAX   = {MANT_W{1'b1}};
	localparam logic [FRAC_W-1:0]     FRAC_MAX   = {FRAC_W{1'b1}};

	// ASCII codes.
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HEAD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BROADCAST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ID_MIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ID_MAX    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL     = 3'd5;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVALID  = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	// One received byte together with its classification.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_head;
		logic       is_tail;
		logic       id_bad;
		logic       id_foreign;
		logic       is_upper;
		logic       is_digit;
		logic       is_sign;
		logic       is_minus;
		logic       is_dot;
		logic [3:0] digit;
	} class_t;

	// Push side of the queue between front and back.
	typedef struct packed {
		logic   valid;
		class_t rec;
	} push_t;

	// Pop side of the queue towards the back end.
	typedef struct packed {
		logic   valid;
		class_t rec;
	} pop_t;

endpackage

// ===== design/acfp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp interfaces: byte, result and configuration channels
// Each channel carries valid, ready and its payload, with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface acfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acfp_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [7:0]                 node_id;
	logic [7:0]                 command_letter;
	logic [7:0]                 subcommand_letter;
	logic                       param_present;
	logic                       param_negative;
	logic [acfp_pkg::MANT_W-1:0] param_mantissa;
	logic [acfp_pkg::FRAC_W-1:0] param_frac_digits;

	modport source (output valid, output status, output node_id, output command_letter,
		output subcommand_letter, output param_present, output param_negative,
		output param_mantissa, output param_frac_digits, input ready);
	modport sink   (input valid, input status, input node_id, input command_letter,
		input subcommand_letter, input param_present, input param_negative,
		input param_mantissa, input param_frac_digits, output ready);
endinterface

interface acfp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [acfp_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/acfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp_front: configuration registers and byte classifier
// Holds the six configuration registers and classifies every accepted byte
// against them, pushing the classified record into the queue.
// ----------------------------------------------------------------------------
module acfp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	acfp_cfg_if.sink              cfg,
	acfp_byte_if.sink             rx,
	input  logic                  q_full,
	output acfp_pkg::push_t       push
);

	logic [7:0] head_q, tail_q, bcast_q, id_min_q, id_max_q, local_q;
	logic [7:0] b;
	acfp_pkg::class_t rec;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= 8'd60;
			tail_q   <= 8'd62;
			bcast_q  <= 8'd0;
			id_min_q <= 8'd1;
			id_max_q <= 8'd254;
			local_q  <= 8'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				acfp_pkg::REG_HEAD:      head_q   <= cfg.data;
				acfp_pkg::REG_TAIL:      tail_q   <= cfg.data;
				acfp_pkg::REG_BROADCAST: bcast_q  <= cfg.data;
				acfp_pkg::REG_ID_MIN:    id_min_q <= cfg.data;
				acfp_pkg::REG_ID_MAX:    id_max_q <= cfg.data;
				acfp_pkg::REG_LOCAL:     local_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Classify the incoming byte; the back end picks the flags it needs by phase.
	assign b = rx.rx_byte;
	always_comb begin
		rec.rx_byte    = b;
		rec.is_head    = (b == head_q);
		rec.is_tail    = (b == tail_q);
		rec.id_bad     = !((b == bcast_q) || ((b >= id_min_q) && (b <= id_max_q)));
		rec.id_foreign = !((b == bcast_q) || (b == local_q));
		rec.is_upper   = (b >= acfp_pkg::CH_UPPER_A) && (b <= acfp_pkg::CH_UPPER_Z);
		rec.is_digit   = (b >= acfp_pkg::CH_ZERO) && (b <= acfp_pkg::CH_NINE);
		rec.is_sign    = (b == acfp_pkg::CH_PLUS) || (b == acfp_pkg::CH_MINUS);
		rec.is_minus   = (b == acfp_pkg::CH_MINUS);
		rec.is_dot     = (b == acfp_pkg::CH_DOT);
		rec.digit      = b[3:0];
	end

	// A byte is accepted whenever the queue has room.
	assign rx.ready   = !q_full;
	assign push.valid = rx.valid && !q_full;
	assign push.rec   = rec;

endmodule

// ===== design/acfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp_queue: two-entry queue of classified bytes
// Decouples the classifier from the frame sequencer so that either side may
// stall without at once holding up the other.
// ----------------------------------------------------------------------------
module acfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  acfp_pkg::push_t  push,
	output logic             full,
	output acfp_pkg::pop_t   pop,
	input  logic             pop_take
);

	acfp_pkg::class_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == 2'd2);
	assign pop.valid = (count_q != 2'd0);
	assign pop.rec   = ent_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop_take && pop.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push.rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/acfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfp_back: frame sequencer, decimal accumulator and result register
// Walks each classified byte through the frame phases, accumulates the
// parameter text and presents one result per frame in an output register.
// ----------------------------------------------------------------------------
module acfp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  acfp_pkg::pop_t  pop,
	output logic            pop_take,
	acfp_result_if.source   result
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_ID   = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_SUB  = 3'd3;
	localparam logic [2:0] PH_TEXT = 3'd4;

	localparam int PROD_W = acfp_pkg::MANT_W + 4;

	logic [2:0]                        phase_q;
	logic [7:0]                        held_id_q, held_cmd_q, held_sub_q;
	logic                              ef_id_q, ef_addr_q, ef_letter_q;
	logic [acfp_pkg::TEXT_CNT_W-1:0]   text_cnt_q;
	logic                              nf_digit_q, nf_dot_q, nf_neg_q, nf_bad_q;
	logic [acfp_pkg::MANT_W-1:0]       mant_q;
	logic [acfp_pkg::FRAC_W-1:0]       frac_q;

	logic                              out_valid_q;
	logic [1:0]                        out_status_q;
	logic [7:0]                        out_id_q, out_cmd_q, out_sub_q;
	logic                              out_has_q, out_neg_q;
	logic [acfp_pkg::MANT_W-1:0]       out_mant_q;
	logic [acfp_pkg::FRAC_W-1:0]       out_frac_q;

	acfp_pkg::class_t                  r;
	logic                              step;
	logic                              emit;
	logic [PROD_W-1:0]                 prod;
	logic [acfp_pkg::MANT_W-1:0]       mant_next;
	logic                              text_room;
	logic [1:0]                        status;
	logic                              param_ok;

	assign r        = pop.rec;
	assign pop_take = !out_valid_q || result.ready;
	assign step     = pop.valid && pop_take;
	assign emit     = step && (phase_q == PH_TEXT) && r.is_tail;

	// Times-ten accumulate with saturation at the top of the mantissa range.
	assign prod = PROD_W'({mant_q, 3'b000}) + PROD_W'({mant_q, 1'b0}) + PROD_W'(r.digit);
	assign mant_next = (prod[PROD_W-1:acfp_pkg::MANT_W] != 4'd0) ? acfp_pkg::MANT_MAX
		: prod[acfp_pkg::MANT_W-1:0];
	assign text_room = (text_cnt_q < acfp_pkg::TEXT_LIMIT);

	// Status of the frame closed by the tail byte, in priority order.
	always_comb begin
		param_ok = 1'b0;
		if (ef_id_q) begin
			status = acfp_pkg::STATUS_INVALID;
		end else if (ef_addr_q) begin
			status = acfp_pkg::STATUS_MISMATCH;
		end else if (ef_letter_q || !text_room) begin
			status = acfp_pkg::STATUS_INVALID;
		end else if (text_cnt_q == '0) begin
			status = acfp_pkg::STATUS_OK;
		end else if (nf_bad_q || !nf_digit_q) begin
			status = acfp_pkg::STATUS_INVALID;
		end else begin
			status   = acfp_pkg::STATUS_OK;
			param_ok = 1'b1;
		end
	end

	// Frame sequencer and parameter accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			held_id_q   <= '0;
			held_cmd_q  <= '0;
			held_sub_q  <= '0;
			ef_id_q     <= 1'b0;
			ef_addr_q   <= 1'b0;
			ef_letter_q <= 1'b0;
			text_cnt_q  <= '0;
			nf_digit_q  <= 1'b0;
			nf_dot_q    <= 1'b0;
			nf_neg_q    <= 1'b0;
			nf_bad_q    <= 1'b0;
			mant_q      <= '0;
			frac_q      <= '0;
		end else if (step) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (r.is_head) begin
						phase_q     <= PH_ID;
						ef_id_q     <= 1'b0;
						ef_addr_q   <= 1'b0;
						ef_letter_q <= 1'b0;
						text_cnt_q  <= '0;
						nf_digit_q  <= 1'b0;
						nf_dot_q    <= 1'b0;
						nf_neg_q    <= 1'b0;
						nf_bad_q    <= 1'b0;
						mant_q      <= '0;
						frac_q      <= '0;
					end
				end
				PH_ID: begin
					held_id_q <= r.rx_byte;
					ef_id_q   <= r.id_bad;
					ef_addr_q <= r.id_foreign;
					phase_q   <= PH_CMD;
				end
				PH_CMD: begin
					held_cmd_q  <= r.rx_byte;
					ef_letter_q <= ef_letter_q || !r.is_upper;
					phase_q     <= PH_SUB;
				end
				PH_SUB: begin
					held_sub_q  <= r.rx_byte;
					ef_letter_q <= ef_letter_q || !r.is_upper;
					phase_q     <= PH_TEXT;
				end
				PH_TEXT: begin
					if (r.is_tail) begin
						phase_q <= PH_HUNT;
					end else if (text_room) begin
						text_cnt_q <= text_cnt_q + acfp_pkg::TEXT_CNT_W'(1);
						if ((text_cnt_q == '0) && r.is_sign) begin
							if (r.is_minus) begin
								nf_neg_q <= 1'b1;
							end
						end else if (r.is_digit) begin
							nf_digit_q <= 1'b1;
							mant_q     <= mant_next;
							if (nf_dot_q && (frac_q != acfp_pkg::FRAC_MAX)) begin
								frac_q <= frac_q + acfp_pkg::FRAC_W'(1);
							end
						end else if (r.is_dot && !nf_dot_q) begin
							nf_dot_q <= 1'b1;
						end else begin
							nf_bad_q <= 1'b1;
						end
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= status;
			out_id_q     <= held_id_q;
			out_cmd_q    <= held_cmd_q;
			out_sub_q    <= held_sub_q;
			out_has_q    <= param_ok;
			out_neg_q    <= param_ok && nf_neg_q;
			out_mant_q   <= param_ok ? mant_q : '0;
			out_frac_q   <= param_ok ? frac_q : '0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.status            = out_status_q;
	assign result.node_id           = out_id_q;
	assign result.command_letter    = out_cmd_q;
	assign result.subcommand_letter = out_sub_q;
	assign result.param_present     = out_has_q;
	assign result.param_negative    = out_neg_q;
	assign result.param_mantissa    = out_mant_q;
	assign result.param_frac_digits = out_frac_q;

endmodule

// ===== design/ascii_command_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_command_frame_parser: framed ASCII command decoder
// Received bytes enter on the rx channel, one per transaction. A frame opens
// at the head byte and carries a driver id, a command letter, a subcommand
// letter and optional signed decimal text; the first tail byte at frame
// index four or later closes it and yields one transaction on the result
// channel with status, the three header bytes and the decimal value
// (mantissa, fraction digit count, sign); the mantissa saturates at its top.
// Bytes outside a frame give nothing. The cfg channel writes the six 8-bit
// registers; it is always ready and must be written only while the parser
// is idle, which the block itself does not enforce. Throughput is one byte
// per cycle while the result receiver does not stall. Each byte is registered
// in the two-entry queue, and the sequencer loads the result into the output
// register at the edge that takes the tail byte from the queue. When the
// result receiver stalls, the held result waits in the output register, the
// sequencer stops and the queue fills; rx.ready falls only once both queue
// entries are taken. Reset restores the configuration defaults, empties the
// queue and puts the sequencer back to hunting for the head byte.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	acfp_cfg_if.sink      cfg,
	acfp_byte_if.sink     rx,
	acfp_result_if.source result
);

	acfp_pkg::push_t push;
	acfp_pkg::pop_t  pop;
	logic            q_full;
	logic            pop_take;

	acfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.q_full (q_full),
		.push   (push)
	);

	acfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.pop      (pop),
		.pop_take (pop_take)
	);

	acfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_take (pop_take),
		.result   (result)
	);

endmodule
